// ----- design/acs_pkg.sv -----
// ----------------------------------------------------------------------------
// acs_pkg - Arabic contextual shaper shared definitions
// Letter form table, mark and joining classes, controller/datapath bundles.
// ----------------------------------------------------------------------------
`default_nettype none

package acs_pkg;

    localparam int unsigned CODE_W = 21;

    localparam logic [CODE_W-1:0] LAM      = 21'h000644;
    localparam logic [CODE_W-1:0] TATWEEL  = 21'h000640;

    // one row of the presentation form table
    typedef struct packed {
        logic        hit;
        logic [15:0] iso;
        logic [15:0] fin;
        logic [15:0] ini;
        logic [15:0] med;
    } t_form;

    // output selection codes
    typedef enum logic [1:0] {
        OSEL_IN   = 2'd0,
        OSEL_LIG  = 2'd1,
        OSEL_PEND = 2'd2,
        OSEL_MARK = 2'd3
    } t_osel;

    // commands from controller to datapath
    typedef struct packed {
        logic  in_ready;
        logic  accept;
        logic  store_mark;
        logic  set_ovf;
        logic  pend_from_in;
        logic  nj_clear;
        logic  advance;
        logic  lig_clear;
        logic  run_clear;
        logic  idx_inc;
        logic  emit;
        t_osel emit_sel;
        logic  emit_done;
    } t_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic in_valid;
        logic in_last;
        logic in_mark;
        logic in_lig;
        logic pend_valid;
        logic marks_full;
        logic cnt_zero;
        logic idx_last;
        logic out_free;
    } t_stat;

    function automatic t_form fr(input logic [15:0] iso, input logic [15:0] fin,
                                 input logic [15:0] ini, input logic [15:0] med);
        t_form f;
        f.hit = 1'b1;
        f.iso = iso;
        f.fin = fin;
        f.ini = ini;
        f.med = med;
        return f;
    endfunction

    function automatic t_form form_lookup(input logic [CODE_W-1:0] c);
        t_form f;
        f = '0;
        case (c)
            21'h000621: f = fr(16'hFE80, 16'h0000, 16'h0000, 16'h0000);
            21'h000622: f = fr(16'hFE81, 16'hFE82, 16'h0000, 16'h0000);
            21'h000623: f = fr(16'hFE83, 16'hFE84, 16'h0000, 16'h0000);
            21'h000624: f = fr(16'hFE85, 16'hFE86, 16'h0000, 16'h0000);
            21'h000625: f = fr(16'hFE87, 16'hFE88, 16'h0000, 16'h0000);
            21'h000626: f = fr(16'hFE89, 16'hFE8A, 16'hFE8B, 16'hFE8C);
            21'h000627: f = fr(16'hFE8D, 16'hFE8E, 16'h0000, 16'h0000);
            21'h000628: f = fr(16'hFE8F, 16'hFE90, 16'hFE91, 16'hFE92);
            21'h000629: f = fr(16'hFE93, 16'hFE94, 16'h0000, 16'h0000);
            21'h00062A: f = fr(16'hFE95, 16'hFE96, 16'hFE97, 16'hFE98);
            21'h00062B: f = fr(16'hFE99, 16'hFE9A, 16'hFE9B, 16'hFE9C);
            21'h00062C: f = fr(16'hFE9D, 16'hFE9E, 16'hFE9F, 16'hFEA0);
            21'h00062D: f = fr(16'hFEA1, 16'hFEA2, 16'hFEA3, 16'hFEA4);
            21'h00062E: f = fr(16'hFEA5, 16'hFEA6, 16'hFEA7, 16'hFEA8);
            21'h00062F: f = fr(16'hFEA9, 16'hFEAA, 16'h0000, 16'h0000);
            21'h000630: f = fr(16'hFEAB, 16'hFEAC, 16'h0000, 16'h0000);
            21'h000631: f = fr(16'hFEAD, 16'hFEAE, 16'h0000, 16'h0000);
            21'h000632: f = fr(16'hFEAF, 16'hFEB0, 16'h0000, 16'h0000);
            21'h000633: f = fr(16'hFEB1, 16'hFEB2, 16'hFEB3, 16'hFEB4);
            21'h000634: f = fr(16'hFEB5, 16'hFEB6, 16'hFEB7, 16'hFEB8);
            21'h000635: f = fr(16'hFEB9, 16'hFEBA, 16'hFEBB, 16'hFEBC);
            21'h000636: f = fr(16'hFEBD, 16'hFEBE, 16'hFEBF, 16'hFEC0);
            21'h000637: f = fr(16'hFEC1, 16'hFEC2, 16'hFEC3, 16'hFEC4);
            21'h000638: f = fr(16'hFEC5, 16'hFEC6, 16'hFEC7, 16'hFEC8);
            21'h000639: f = fr(16'hFEC9, 16'hFECA, 16'hFECB, 16'hFECC);
            21'h00063A: f = fr(16'hFECD, 16'hFECE, 16'hFECF, 16'hFED0);
            21'h000641: f = fr(16'hFED1, 16'hFED2, 16'hFED3, 16'hFED4);
            21'h000642: f = fr(16'hFED5, 16'hFED6, 16'hFED7, 16'hFED8);
            21'h000643: f = fr(16'hFED9, 16'hFEDA, 16'hFEDB, 16'hFEDC);
            21'h000644: f = fr(16'hFEDD, 16'hFEDE, 16'hFEDF, 16'hFEE0);
            21'h000645: f = fr(16'hFEE1, 16'hFEE2, 16'hFEE3, 16'hFEE4);
            21'h000646: f = fr(16'hFEE5, 16'hFEE6, 16'hFEE7, 16'hFEE8);
            21'h000647: f = fr(16'hFEE9, 16'hFEEA, 16'hFEEB, 16'hFEEC);
            21'h000648: f = fr(16'hFEED, 16'hFEEE, 16'h0000, 16'h0000);
            21'h000649: f = fr(16'hFEEF, 16'hFEF0, 16'h0000, 16'h0000);
            21'h00064A: f = fr(16'hFEF1, 16'hFEF2, 16'hFEF3, 16'hFEF4);
            21'h000671: f = fr(16'hFB50, 16'hFB51, 16'h0000, 16'h0000);
            21'h000679: f = fr(16'hFB66, 16'hFB67, 16'hFB68, 16'hFB69);
            21'h00067A: f = fr(16'hFB5E, 16'hFB5F, 16'hFB60, 16'hFB61);
            21'h00067B: f = fr(16'hFB52, 16'hFB53, 16'hFB54, 16'hFB55);
            21'h00067E: f = fr(16'hFB56, 16'hFB57, 16'hFB58, 16'hFB59);
            21'h00067F: f = fr(16'hFB62, 16'hFB63, 16'hFB64, 16'hFB65);
            21'h000680: f = fr(16'hFB5A, 16'hFB5B, 16'hFB5C, 16'hFB5D);
            21'h000683: f = fr(16'hFB76, 16'hFB77, 16'hFB78, 16'hFB79);
            21'h000684: f = fr(16'hFB72, 16'hFB73, 16'hFB74, 16'hFB75);
            21'h000686: f = fr(16'hFB7A, 16'hFB7B, 16'hFB7C, 16'hFB7D);
            21'h000687: f = fr(16'hFB7E, 16'hFB7F, 16'hFB80, 16'hFB81);
            21'h000688: f = fr(16'hFB88, 16'hFB89, 16'h0000, 16'h0000);
            21'h00068C: f = fr(16'hFB84, 16'hFB85, 16'h0000, 16'h0000);
            21'h00068D: f = fr(16'hFB82, 16'hFB83, 16'h0000, 16'h0000);
            21'h00068E: f = fr(16'hFB86, 16'hFB87, 16'h0000, 16'h0000);
            21'h000691: f = fr(16'hFB8C, 16'hFB8D, 16'h0000, 16'h0000);
            21'h000698: f = fr(16'hFB8A, 16'hFB8B, 16'h0000, 16'h0000);
            21'h0006A4: f = fr(16'hFB6A, 16'hFB6B, 16'hFB6C, 16'hFB6D);
            21'h0006A6: f = fr(16'hFB6E, 16'hFB6F, 16'hFB70, 16'hFB71);
            21'h0006A9: f = fr(16'hFB8E, 16'hFB8F, 16'hFB90, 16'hFB91);
            21'h0006AD: f = fr(16'hFBD3, 16'hFBD4, 16'hFBD5, 16'hFBD6);
            21'h0006AF: f = fr(16'hFB92, 16'hFB93, 16'hFB94, 16'hFB95);
            21'h0006B1: f = fr(16'hFB9A, 16'hFB9B, 16'hFB9C, 16'hFB9D);
            21'h0006B3: f = fr(16'hFB96, 16'hFB97, 16'hFB98, 16'hFB99);
            21'h0006BA: f = fr(16'hFB9E, 16'hFB9F, 16'h0000, 16'h0000);
            21'h0006BB: f = fr(16'hFBA0, 16'hFBA1, 16'hFBA2, 16'hFBA3);
            21'h0006BE: f = fr(16'hFBAA, 16'hFBAB, 16'hFBAC, 16'hFBAD);
            21'h0006C0: f = fr(16'hFBA4, 16'hFBA5, 16'h0000, 16'h0000);
            21'h0006C1: f = fr(16'hFBA6, 16'hFBA7, 16'hFBA8, 16'hFBA9);
            21'h0006C5: f = fr(16'hFBE0, 16'hFBE1, 16'h0000, 16'h0000);
            21'h0006C6: f = fr(16'hFBD9, 16'hFBDA, 16'h0000, 16'h0000);
            21'h0006C7: f = fr(16'hFBD7, 16'hFBD8, 16'h0000, 16'h0000);
            21'h0006C8: f = fr(16'hFBDB, 16'hFBDC, 16'h0000, 16'h0000);
            21'h0006C9: f = fr(16'hFBE2, 16'hFBE3, 16'h0000, 16'h0000);
            21'h0006CB: f = fr(16'hFBDE, 16'hFBDF, 16'h0000, 16'h0000);
            21'h0006CC: f = fr(16'hFBFC, 16'hFBFD, 16'hFBFE, 16'hFBFF);
            21'h0006D0: f = fr(16'hFBE4, 16'hFBE5, 16'hFBE6, 16'hFBE7);
            21'h0006D2: f = fr(16'hFBAE, 16'hFBAF, 16'h0000, 16'h0000);
            21'h0006D3: f = fr(16'hFBB0, 16'hFBB1, 16'h0000, 16'h0000);
            default:    f = '0;
        endcase
        return f;
    endfunction

    // harakat and Quranic annotation marks
    function automatic logic is_mark(input logic [CODE_W-1:0] c);
        return (c >= 21'h00064B && c <= 21'h00065F) || (c == 21'h000670) ||
               (c >= 21'h0006D6 && c <= 21'h0006ED);
    endfunction

    function automatic logic links_fwd(input logic [CODE_W-1:0] c);
        t_form f;
        f = form_lookup(c);
        return (c == TATWEEL) || (f.hit && (f.ini != 16'h0000));
    endfunction

    function automatic logic links_bwd(input logic [CODE_W-1:0] c);
        t_form f;
        f = form_lookup(c);
        return (c == TATWEEL) || (f.hit && (f.fin != 16'h0000));
    endfunction

    // alefs that fuse with a preceding lam
    function automatic logic lig_hit(input logic [CODE_W-1:0] c);
        return (c == 21'h000622) || (c == 21'h000623) ||
               (c == 21'h000625) || (c == 21'h000627);
    endfunction

    function automatic logic [CODE_W-1:0] lig_code(input logic [CODE_W-1:0] c,
                                                   input logic fin);
        logic [15:0] g;
        case (c)
            21'h000622: g = fin ? 16'hFEF6 : 16'hFEF5;
            21'h000623: g = fin ? 16'hFEF8 : 16'hFEF7;
            21'h000625: g = fin ? 16'hFEFA : 16'hFEF9;
            default:    g = fin ? 16'hFEFC : 16'hFEFB;
        endcase
        return {5'd0, g};
    endfunction

    function automatic logic [CODE_W-1:0] pick_form(input logic [CODE_W-1:0] c,
                                                    input logic prev_j,
                                                    input logic next_j);
        t_form       f;
        logic        jp;
        logic        jn;
        logic [15:0] g;
        f  = form_lookup(c);
        jp = prev_j && (f.fin != 16'h0000);
        jn = next_j && (f.ini != 16'h0000);
        if (jp && jn)  g = f.med;
        else if (jp)   g = f.fin;
        else if (jn)   g = f.ini;
        else           g = f.iso;
        if (!f.hit || g == 16'h0000) return c;
        return {5'd0, g};
    endfunction

endpackage

`default_nettype wire

// ----- design/acs_in_if.sv -----
// ----------------------------------------------------------------------------
// acs_in_if - codepoint input channel
// valid/ready channel carrying one codepoint and its end-of-run flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface acs_in_if;
    logic        valid;
    logic        ready;
    logic [20:0] code_in;
    logic        run_end;

    modport source (output valid, output code_in, output run_end, input ready);
    modport sink   (input valid, input code_in, input run_end, output ready);
endinterface

`default_nettype wire

// ----- design/acs_out_if.sv -----
// ----------------------------------------------------------------------------
// acs_out_if - shaped codepoint output channel
// valid/ready channel carrying one shaped codepoint with run flags.
// ----------------------------------------------------------------------------
`default_nettype none

interface acs_out_if;
    logic        valid;
    logic        ready;
    logic [20:0] code_out;
    logic        run_done;
    logic        marks_lost;

    modport source (output valid, output code_out, output run_done,
                    output marks_lost, input ready);
    modport sink   (input valid, input code_out, input run_done,
                    input marks_lost, output ready);
endinterface

`default_nettype wire

// ----- design/acs_ctrl.sv -----
// ----------------------------------------------------------------------------
// acs_ctrl - shaper sequencer
// Decides per item which results go out and steps through the mark buffer.
// ----------------------------------------------------------------------------
`default_nettype none

module acs_ctrl (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire acs_pkg::t_stat i_stat,
    output acs_pkg::t_cmd       o_cmd
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_ONE   = 5'b00010,
        S_LIG   = 5'b00100,
        S_PEND  = 5'b01000,
        S_MARKS = 5'b10000
    } t_state;

    t_state r_state, n_state;
    logic   r_flush, n_flush;
    logic   r_last,  n_last;
    logic   w_accept;

    assign w_accept = i_stat.in_valid && (r_state == S_IDLE);

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_flush <= 1'b0;
            r_last  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_flush <= n_flush;
            r_last  <= n_last;
        end
    end

    // next state and commands
    always_comb begin
        n_state  = r_state;
        n_flush  = r_flush;
        n_last   = r_last;
        o_cmd    = '0;
        o_cmd.in_ready = (r_state == S_IDLE);
        o_cmd.emit_sel = acs_pkg::OSEL_IN;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    o_cmd.accept = 1'b1;
                    n_last       = i_stat.in_last;
                    if (i_stat.in_mark) begin
                        if (!i_stat.pend_valid) begin
                            n_state = S_ONE;
                        end else begin
                            if (i_stat.marks_full) o_cmd.set_ovf = 1'b1;
                            else                   o_cmd.store_mark = 1'b1;
                            if (i_stat.in_last) begin
                                o_cmd.nj_clear = 1'b1;
                                n_flush        = 1'b1;
                                n_state        = S_PEND;
                            end
                        end
                    end else if (i_stat.pend_valid) begin
                        if (i_stat.in_lig) begin
                            n_state = S_LIG;
                        end else begin
                            n_flush = 1'b0;
                            n_state = S_PEND;
                        end
                    end else begin
                        o_cmd.pend_from_in = 1'b1;
                        if (i_stat.in_last) begin
                            o_cmd.nj_clear = 1'b1;
                            n_flush        = 1'b1;
                            n_state        = S_PEND;
                        end
                    end
                end
            end
            S_ONE: begin
                if (i_stat.out_free) begin
                    o_cmd.emit      = 1'b1;
                    o_cmd.emit_sel  = acs_pkg::OSEL_IN;
                    o_cmd.emit_done = r_last;
                    o_cmd.run_clear = r_last;
                    n_state         = S_IDLE;
                end
            end
            S_LIG: begin
                if (i_stat.out_free) begin
                    o_cmd.emit      = 1'b1;
                    o_cmd.emit_sel  = acs_pkg::OSEL_LIG;
                    o_cmd.emit_done = r_last;
                    o_cmd.lig_clear = 1'b1;
                    o_cmd.run_clear = r_last;
                    n_state         = S_IDLE;
                end
            end
            S_PEND, S_MARKS: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (r_state == S_PEND) begin
                        o_cmd.emit_sel  = acs_pkg::OSEL_PEND;
                        o_cmd.emit_done = r_flush && i_stat.cnt_zero;
                    end else begin
                        o_cmd.emit_sel  = acs_pkg::OSEL_MARK;
                        o_cmd.emit_done = r_flush && i_stat.idx_last;
                        o_cmd.idx_inc   = 1'b1;
                    end
                    // sequence ends after the pending letter or the last mark
                    if ((r_state == S_PEND && i_stat.cnt_zero) ||
                        (r_state == S_MARKS && i_stat.idx_last)) begin
                        if (r_flush) begin
                            o_cmd.run_clear = 1'b1;
                            n_state         = S_IDLE;
                        end else begin
                            o_cmd.advance = 1'b1;
                            if (r_last) begin
                                n_flush = 1'b1;
                                n_state = S_PEND;
                            end else begin
                                n_state = S_IDLE;
                            end
                        end
                    end else begin
                        n_state = S_MARKS;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // checks
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit |-> i_stat.out_free) else $error("emit into busy output");
    a_idle_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !o_cmd.emit) else $error("emit while idle");
    a_one_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ONE && i_stat.out_free) |=> (r_state == S_IDLE))
        else $error("single result did not return to idle");
    a_done_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.emit && o_cmd.emit_done) |-> o_cmd.run_clear)
        else $error("run end without run clear");

endmodule

`default_nettype wire

// ----- design/acs_dp.sv -----
// ----------------------------------------------------------------------------
// acs_dp - shaper datapath
// Pending letter, mark buffer, joining flags and the registered output item.
// ----------------------------------------------------------------------------
`default_nettype none

module acs_dp #(
    parameter int unsigned MAX_MARKS = 8
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    acs_in_if.sink              i_in,
    acs_out_if.source           o_out,
    input  wire acs_pkg::t_cmd  i_cmd,
    output acs_pkg::t_stat      o_stat
);

    localparam int unsigned IW = (MAX_MARKS > 1) ? $clog2(MAX_MARKS) : 1;
    localparam int unsigned CW = $clog2(MAX_MARKS + 1);

    logic [20:0]   r_marks [MAX_MARKS];
    logic [CW-1:0] r_cnt;
    logic [IW-1:0] r_idx;
    logic          r_pv;
    logic          r_bjf;
    logic          r_ovf;
    logic          r_nj;
    logic [20:0]   r_pend;
    logic [20:0]   r_c;
    logic          r_ovalid;
    logic [20:0]   r_ocode;
    logic          r_odone;
    logic          r_olost;
    logic [20:0]   w_emit_code;

    assign i_in.ready = i_cmd.in_ready;

    // status towards the sequencer
    always_comb begin
        o_stat.in_valid   = i_in.valid;
        o_stat.in_last    = i_in.run_end;
        o_stat.in_mark    = acs_pkg::is_mark(i_in.code_in);
        o_stat.in_lig     = (r_pend == acs_pkg::LAM) && acs_pkg::lig_hit(i_in.code_in);
        o_stat.pend_valid = r_pv;
        o_stat.marks_full = (r_cnt == CW'(MAX_MARKS));
        o_stat.cnt_zero   = (r_cnt == '0);
        o_stat.idx_last   = ((CW'(r_idx) + 1'b1) == r_cnt);
        o_stat.out_free   = !r_ovalid || o_out.ready;
    end

    // result selection
    always_comb begin
        case (i_cmd.emit_sel)
            acs_pkg::OSEL_IN:   w_emit_code = r_c;
            acs_pkg::OSEL_LIG:  w_emit_code = acs_pkg::lig_code(r_c, r_bjf);
            acs_pkg::OSEL_PEND: w_emit_code = acs_pkg::pick_form(r_pend, r_bjf, r_nj);
            acs_pkg::OSEL_MARK: w_emit_code = r_marks[r_idx];
            default:            w_emit_code = r_c;
        endcase
    end

    // mark buffer
    always_ff @(posedge i_clk) begin
        if (i_cmd.store_mark) begin
            r_marks[r_cnt[IW-1:0]] <= i_in.code_in;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) r_c <= i_in.code_in;
        if (i_cmd.pend_from_in) r_pend <= i_in.code_in;
        if (i_cmd.advance) r_pend <= r_c;
        if (i_cmd.emit) begin
            r_ocode <= w_emit_code;
            r_odone <= i_cmd.emit_done;
            r_olost <= r_ovf;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv     <= 1'b0;
            r_bjf    <= 1'b0;
            r_ovf    <= 1'b0;
            r_nj     <= 1'b0;
            r_cnt    <= '0;
            r_idx    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cmd.accept) r_nj <= acs_pkg::links_bwd(i_in.code_in);
            if (i_cmd.nj_clear) r_nj <= 1'b0;
            if (i_cmd.store_mark) r_cnt <= r_cnt + 1'b1;
            if (i_cmd.set_ovf) r_ovf <= 1'b1;
            if (i_cmd.pend_from_in) r_pv <= 1'b1;
            if (i_cmd.idx_inc) r_idx <= r_idx + 1'b1;
            if (i_cmd.advance) begin
                r_bjf <= acs_pkg::links_fwd(r_pend);
                r_cnt <= '0;
                r_idx <= '0;
                r_nj  <= 1'b0;
            end
            if (i_cmd.lig_clear) begin
                r_pv  <= 1'b0;
                r_bjf <= 1'b0;
                r_cnt <= '0;
                r_idx <= '0;
            end
            if (i_cmd.run_clear) begin
                r_pv  <= 1'b0;
                r_bjf <= 1'b0;
                r_ovf <= 1'b0;
                r_nj  <= 1'b0;
                r_cnt <= '0;
                r_idx <= '0;
            end
            if (i_cmd.emit) r_ovalid <= 1'b1;
            else if (o_out.ready) r_ovalid <= 1'b0;
        end
    end

    assign o_out.valid      = r_ovalid;
    assign o_out.code_out   = r_ocode;
    assign o_out.run_done   = r_odone;
    assign o_out.marks_lost = r_olost;

endmodule

`default_nettype wire

// ----- design/arabic_contextual_shaper_unit.sv -----
// ----------------------------------------------------------------------------
// arabic_contextual_shaper_unit - Arabic presentation form shaper
// Replaces letters of a right-to-left run by their contextual forms.
// ----------------------------------------------------------------------------
// Usage:
//   i_in carries codepoints of one run in logical order; run_end flags the
//   last one. o_out carries shaped codepoints, run_done on the final result
//   of a run and marks_lost once a mark of the run overflowed the buffer.
//   A letter is held until the next non-mark codepoint decides its form;
//   up to MAX_MARKS marks are held behind it.
//   Flow: an item is taken only while the sequencer is idle, then each of
//   its results is moved into the output register in turn, and no new item
//   is taken before the last of them is. A letter followed by k marks that
//   is not fused into a lam-alef ligature gives k+1 results: the letter,
//   then its marks as the sequencer steps through the mark buffer.
//   A result waits in the output register while the receiver stalls; the
//   sequencer holds and no new item is taken until it can move on.
//   Reset (synchronous, active low) empties the pending letter, the mark
//   count, the overflow flag and the output register at once.
// ----------------------------------------------------------------------------
`default_nettype none

module arabic_contextual_shaper_unit #(
    parameter int unsigned MAX_MARKS = 8
) (
    input  wire       i_clk,
    input  wire       i_rst_n,
    acs_in_if.sink    i_in,
    acs_out_if.source o_out
);

    acs_pkg::t_cmd  w_cmd;
    acs_pkg::t_stat w_stat;

    acs_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd)
    );

    acs_dp #(
        .MAX_MARKS (MAX_MARKS)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .o_out   (o_out),
        .i_cmd   (w_cmd),
        .o_stat  (w_stat)
    );

endmodule

`default_nettype wire

// ----- tb/sv/tb_arabic_contextual_shaper_unit.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb - regression bench for arabic_contextual_shaper_unit
// Directed runs (forms, marks, overflow, lam-alef, pass-through), then random
// runs. Results are checked against a local shaping predictor or a row's own
// expected code; both channels idle in random bursts, none near the end.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;

    localparam int MARK_DEPTH = 8;
    localparam int N_RANDOM   = 256;

    typedef struct packed {
        logic [20:0] code;
        logic        done;
        logic        lost;
    } t_shaped;

    typedef struct {
        logic [20:0] code;
        logic        last;
        logic        has_exp;
        logic [20:0] exp_code;
    } t_row;

    logic i_clk;
    logic i_rst_n;
    acs_in_if  in_ch ();
    acs_out_if out_ch ();

    arabic_contextual_shaper_unit #(.MAX_MARKS(MARK_DEPTH)) u_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch.sink),
        .o_out  (out_ch.source)
    );

    // clock
    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    // predictor state
    logic        sh_pend_valid;
    logic [20:0] sh_pend_code;
    logic        sh_prev_fwd;
    logic [20:0] sh_marks [MARK_DEPTH];
    int          sh_mark_cnt;
    logic        sh_ovf;

    t_shaped shaped_q [$];
    int      n_errors;
    bit      quiet;
    int      stall_left;

    // form table lookup, written locally
    function automatic logic [63:0] forms_of(input logic [20:0] c);
        case (c)
            21'h621: return 64'hFE80_0000_0000_0000;
            21'h622: return 64'hFE81_FE82_0000_0000;
            21'h623: return 64'hFE83_FE84_0000_0000;
            21'h624: return 64'hFE85_FE86_0000_0000;
            21'h625: return 64'hFE87_FE88_0000_0000;
            21'h626: return 64'hFE89_FE8A_FE8B_FE8C;
            21'h627: return 64'hFE8D_FE8E_0000_0000;
            21'h628: return 64'hFE8F_FE90_FE91_FE92;
            21'h629: return 64'hFE93_FE94_0000_0000;
            21'h62A: return 64'hFE95_FE96_FE97_FE98;
            21'h62B: return 64'hFE99_FE9A_FE9B_FE9C;
            21'h62C: return 64'hFE9D_FE9E_FE9F_FEA0;
            21'h62D: return 64'hFEA1_FEA2_FEA3_FEA4;
            21'h62E: return 64'hFEA5_FEA6_FEA7_FEA8;
            21'h62F: return 64'hFEA9_FEAA_0000_0000;
            21'h630: return 64'hFEAB_FEAC_0000_0000;
            21'h631: return 64'hFEAD_FEAE_0000_0000;
            21'h632: return 64'hFEAF_FEB0_0000_0000;
            21'h633: return 64'hFEB1_FEB2_FEB3_FEB4;
            21'h634: return 64'hFEB5_FEB6_FEB7_FEB8;
            21'h635: return 64'hFEB9_FEBA_FEBB_FEBC;
            21'h636: return 64'hFEBD_FEBE_FEBF_FEC0;
            21'h637: return 64'hFEC1_FEC2_FEC3_FEC4;
            21'h638: return 64'hFEC5_FEC6_FEC7_FEC8;
            21'h639: return 64'hFEC9_FECA_FECB_FECC;
            21'h63A: return 64'hFECD_FECE_FECF_FED0;
            21'h641: return 64'hFED1_FED2_FED3_FED4;
            21'h642: return 64'hFED5_FED6_FED7_FED8;
            21'h643: return 64'hFED9_FEDA_FEDB_FEDC;
            21'h644: return 64'hFEDD_FEDE_FEDF_FEE0;
            21'h645: return 64'hFEE1_FEE2_FEE3_FEE4;
            21'h646: return 64'hFEE5_FEE6_FEE7_FEE8;
            21'h647: return 64'hFEE9_FEEA_FEEB_FEEC;
            21'h648: return 64'hFEED_FEEE_0000_0000;
            21'h649: return 64'hFEEF_FEF0_0000_0000;
            21'h64A: return 64'hFEF1_FEF2_FEF3_FEF4;
            21'h671: return 64'hFB50_FB51_0000_0000;
            21'h679: return 64'hFB66_FB67_FB68_FB69;
            21'h67A: return 64'hFB5E_FB5F_FB60_FB61;
            21'h67B: return 64'hFB52_FB53_FB54_FB55;
            21'h67E: return 64'hFB56_FB57_FB58_FB59;
            21'h67F: return 64'hFB62_FB63_FB64_FB65;
            21'h680: return 64'hFB5A_FB5B_FB5C_FB5D;
            21'h683: return 64'hFB76_FB77_FB78_FB79;
            21'h684: return 64'hFB72_FB73_FB74_FB75;
            21'h686: return 64'hFB7A_FB7B_FB7C_FB7D;
            21'h687: return 64'hFB7E_FB7F_FB80_FB81;
            21'h688: return 64'hFB88_FB89_0000_0000;
            21'h68C: return 64'hFB84_FB85_0000_0000;
            21'h68D: return 64'hFB82_FB83_0000_0000;
            21'h68E: return 64'hFB86_FB87_0000_0000;
            21'h691: return 64'hFB8C_FB8D_0000_0000;
            21'h698: return 64'hFB8A_FB8B_0000_0000;
            21'h6A4: return 64'hFB6A_FB6B_FB6C_FB6D;
            21'h6A6: return 64'hFB6E_FB6F_FB70_FB71;
            21'h6A9: return 64'hFB8E_FB8F_FB90_FB91;
            21'h6AD: return 64'hFBD3_FBD4_FBD5_FBD6;
            21'h6AF: return 64'hFB92_FB93_FB94_FB95;
            21'h6B1: return 64'hFB9A_FB9B_FB9C_FB9D;
            21'h6B3: return 64'hFB96_FB97_FB98_FB99;
            21'h6BA: return 64'hFB9E_FB9F_0000_0000;
            21'h6BB: return 64'hFBA0_FBA1_FBA2_FBA3;
            21'h6BE: return 64'hFBAA_FBAB_FBAC_FBAD;
            21'h6C0: return 64'hFBA4_FBA5_0000_0000;
            21'h6C1: return 64'hFBA6_FBA7_FBA8_FBA9;
            21'h6C5: return 64'hFBE0_FBE1_0000_0000;
            21'h6C6: return 64'hFBD9_FBDA_0000_0000;
            21'h6C7: return 64'hFBD7_FBD8_0000_0000;
            21'h6C8: return 64'hFBDB_FBDC_0000_0000;
            21'h6C9: return 64'hFBE2_FBE3_0000_0000;
            21'h6CB: return 64'hFBDE_FBDF_0000_0000;
            21'h6CC: return 64'hFBFC_FBFD_FBFE_FBFF;
            21'h6D0: return 64'hFBE4_FBE5_FBE6_FBE7;
            21'h6D2: return 64'hFBAE_FBAF_0000_0000;
            21'h6D3: return 64'hFBB0_FBB1_0000_0000;
            default: return 64'h0;
        endcase
    endfunction

    function automatic bit harakat(input logic [20:0] c);
        return (c >= 21'h64B && c <= 21'h65F) || c == 21'h670 ||
               (c >= 21'h6D6 && c <= 21'h6ED);
    endfunction

    function automatic bit joins_fwd(input logic [20:0] c);
        logic [63:0] f;
        f = forms_of(c);
        return c == acs_pkg::TATWEEL || f[31:16] != 16'h0;
    endfunction

    function automatic bit joins_bwd(input logic [20:0] c);
        logic [63:0] f;
        f = forms_of(c);
        return c == acs_pkg::TATWEEL || f[47:32] != 16'h0;
    endfunction

    function automatic logic [20:0] contextual_form(input logic [20:0] c,
                                                    input bit jp_in, input bit jn_in);
        logic [63:0] f;
        logic [15:0] g;
        bit          jp;
        bit          jn;
        f  = forms_of(c);
        jp = jp_in && f[47:32] != 16'h0;
        jn = jn_in && f[31:16] != 16'h0;
        if (f == 64'h0) return c;
        if (jp && jn)  g = f[15:0];
        else if (jp)   g = f[47:32];
        else if (jn)   g = f[31:16];
        else           g = f[63:48];
        return (g != 16'h0) ? {5'd0, g} : c;
    endfunction

    function automatic logic [15:0] lam_alef(input logic [20:0] a, input bit fin);
        case (a)
            21'h622: return fin ? 16'hFEF6 : 16'hFEF5;
            21'h623: return fin ? 16'hFEF8 : 16'hFEF7;
            21'h625: return fin ? 16'hFEFA : 16'hFEF9;
            21'h627: return fin ? 16'hFEFC : 16'hFEFB;
            default: return 16'h0;
        endcase
    endfunction

    // append one expected result
    task automatic add_shaped(input t_shaped s);
        shaped_q.insert(shaped_q.size(), s);
    endtask

    task automatic push_shaped(input logic [20:0] c);
        add_shaped(t_shaped'{code: c, done: 1'b0, lost: sh_ovf});
    endtask

    task automatic flush_marks();
        for (int k = 0; k < sh_mark_cnt; k++) push_shaped(sh_marks[k]);
        sh_mark_cnt = 0;
    endtask

    // predict the results of one accepted codepoint
    task automatic shape_step(input logic [20:0] c, input logic last);
        int          n0;
        logic [15:0] lg;
        n0 = shaped_q.size();
        if (harakat(c)) begin
            if (!sh_pend_valid) push_shaped(c);
            else if (sh_mark_cnt < MARK_DEPTH) sh_marks[sh_mark_cnt++] = c;
            else sh_ovf = 1'b1;
        end else if (sh_pend_valid) begin
            lg = (sh_pend_code == acs_pkg::LAM) ? lam_alef(c, sh_prev_fwd) : 16'h0;
            if (lg != 16'h0) begin
                push_shaped({5'd0, lg});
                sh_mark_cnt   = 0;
                sh_pend_valid = 1'b0;
                sh_prev_fwd   = 1'b0;
            end else begin
                push_shaped(contextual_form(sh_pend_code, sh_prev_fwd, joins_bwd(c)));
                flush_marks();
                sh_prev_fwd  = joins_fwd(sh_pend_code);
                sh_pend_code = c;
            end
        end else begin
            sh_pend_code  = c;
            sh_pend_valid = 1'b1;
        end
        if (last) begin
            if (sh_pend_valid) begin
                push_shaped(contextual_form(sh_pend_code, sh_prev_fwd, 1'b0));
                flush_marks();
            end
            if (shaped_q.size() > n0) shaped_q[$].done = 1'b1;
            sh_pend_valid = 1'b0;
            sh_prev_fwd   = 1'b0;
            sh_mark_cnt   = 0;
            sh_ovf        = 1'b0;
        end
    endtask

    // present one codepoint and wait for the accepting edge
    task automatic drive_code(input logic [20:0] c, input logic last);
        in_ch.valid   <= 1'b1;
        in_ch.code_in <= c;
        in_ch.run_end <= last;
        do @(posedge i_clk); while (!in_ch.ready);
    endtask

    // send one codepoint, at times after a random idle burst
    task automatic send_code(input logic [20:0] c, input logic last);
        if (!quiet && $urandom_range(3) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        drive_code(c, last);
        shape_step(c, last);
    endtask

    // receiver stalls in random bursts
    always @(posedge i_clk) begin
        if (!i_rst_n || quiet) begin
            out_ch.ready <= 1'b1;
            stall_left = 0;
        end else if (stall_left > 0) begin
            out_ch.ready <= 1'b0;
            stall_left--;
        end else if ($urandom_range(4) == 0) begin
            out_ch.ready <= 1'b0;
            stall_left = $urandom_range(0, 5);
        end else begin
            out_ch.ready <= 1'b1;
        end
    end

    // result checker
    always @(posedge i_clk) begin
        t_shaped want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (shaped_q.size() == 0) begin
                $display("%0t: unexpected result code=%h done=%b lost=%b", $time,
                         out_ch.code_out, out_ch.run_done, out_ch.marks_lost);
                n_errors++;
            end else begin
                want = shaped_q.pop_front();
                if (out_ch.code_out !== want.code || out_ch.run_done !== want.done ||
                    out_ch.marks_lost !== want.lost) begin
                    $display("%0t: mismatch expected %h/%b/%b actual %h/%b/%b", $time,
                             want.code, want.done, want.lost, out_ch.code_out,
                             out_ch.run_done, out_ch.marks_lost);
                    n_errors++;
                end
            end
        end
    end

    function automatic logic [20:0] lam_alef_src(input int k);
        case (k)
            0: return 21'h622;
            1: return 21'h623;
            2: return 21'h625;
            default: return 21'h627;
        endcase
    endfunction

    // random codepoint, mostly Arabic
    function automatic logic [20:0] pick_code();
        case ($urandom_range(9))
            0, 1, 2: return 21'(21'h621 + $urandom_range(0, 'h29));
            3:       return 21'(21'h671 + $urandom_range(0, 'h62));
            4:       return acs_pkg::LAM;
            5:       return lam_alef_src($urandom_range(3));
            6:       return acs_pkg::TATWEEL;
            7:       return 21'(21'h64B + $urandom_range(0, 20));
            8:       return 21'($urandom_range(0, 'h1FFFFF));
            default: return 21'($urandom_range(0, 'h7F));
        endcase
    endfunction

    // directed rows: run of codepoints, expected code where obvious
    t_row dir_rows [$];

    task automatic add_row(input logic [20:0] c, input logic last,
                           input logic has_exp = 1'b0, input logic [20:0] e = '0);
        dir_rows.insert(dir_rows.size(),
                        t_row'{code: c, last: last, has_exp: has_exp, exp_code: e});
    endtask

    initial begin
        int   sent;
        int   len;
        int   kind;
        logic [20:0] c;
        n_errors = 0;
        quiet    = 1'b0;
        sh_pend_valid = 1'b0;
        sh_pend_code  = '0;
        sh_prev_fwd   = 1'b0;
        sh_mark_cnt   = 0;
        sh_ovf        = 1'b0;
        in_ch.valid   <= 1'b0;
        in_ch.code_in <= '0;
        in_ch.run_end <= 1'b0;
        i_rst_n       <= 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // isolated beh, code zero, top codepoint, mark with nothing pending
        add_row(21'h628, 1'b1, 1'b1, 21'hFE8F);
        add_row(21'h000000, 1'b1, 1'b1, 21'h000000);
        add_row(21'h1FFFFF, 1'b1, 1'b1, 21'h1FFFFF);
        add_row(21'h64E, 1'b1, 1'b1, 21'h64E);
        // beh-tatweel-beh: initial, medial, final
        add_row(21'h628, 1'b0); add_row(acs_pkg::TATWEEL, 1'b0); add_row(21'h628, 1'b1);
        // lam with a mark then alef, after a joining letter
        add_row(21'h628, 1'b0); add_row(acs_pkg::LAM, 1'b0); add_row(21'h650, 1'b0);
        add_row(21'h627, 1'b0); add_row(21'h628, 1'b1);
        // letter with overflowing marks
        add_row(21'h633, 1'b0);
        for (int k = 0; k < MARK_DEPTH + 2; k++) add_row(21'(21'h6D6 + k), 1'b0);
        add_row(21'h6D3, 1'b1);

        foreach (dir_rows[i]) begin
            if (dir_rows[i].has_exp) begin
                shape_step(dir_rows[i].code, dir_rows[i].last);
                void'(shaped_q.pop_back());
                add_shaped(t_shaped'{code: dir_rows[i].exp_code, done: 1'b1, lost: 1'b0});
                drive_code(dir_rows[i].code, dir_rows[i].last);
            end else begin
                send_code(dir_rows[i].code, dir_rows[i].last);
            end
        end

        // hold off until every result has drained
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (shaped_q.size() != 0) @(posedge i_clk);

        // random runs of well-formed text with noise
        sent = 0;
        while (sent < N_RANDOM) begin
            len = $urandom_range(1, 10);
            for (int k = 0; k < len; k++) begin
                kind = $urandom_range(9);
                if (kind == 0) begin
                    repeat ($urandom_range(1, MARK_DEPTH + 2)) begin
                        send_code(21'(21'h64B + $urandom_range(0, 20)), 1'b0);
                        sent++;
                    end
                end
                c = pick_code();
                if (sent > N_RANDOM - 40) quiet = 1'b1;
                send_code(c, k == len - 1);
                sent++;
            end
        end

        in_ch.valid <= 1'b0;
        while (shaped_q.size() != 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);
        if (n_errors == 0 && shaped_q.size() == 0)
            $display("arabic_contextual_shaper_unit regression: pass");
        else
            $display("arabic_contextual_shaper_unit regression: fail");
        $finish;
    end

    // watchdog
    initial begin
        #2000000;
        $display("arabic_contextual_shaper_unit regression: fail");
        $finish;
    end

endmodule

`default_nettype wire

// ----- sim.f -----
design/acs_pkg.sv
design/acs_in_if.sv
design/acs_out_if.sv
design/acs_ctrl.sv
design/acs_dp.sv
design/arabic_contextual_shaper_unit.sv
tb/sv/tb_arabic_contextual_shaper_unit.sv
